[src/pap_pkg.sv]
// ----------------------------------------------------------------------------
// Arc point generator package
// Shared constants, register codes, the basis interface struct and the
// constant tables for sine, cosine and the color ramps.
// ----------------------------------------------------------------------------
package pap_pkg;

	// Configuration register codes.
	localparam logic [2:0] CFG_NORMAL_X = 3'd0;
	localparam logic [2:0] CFG_NORMAL_Y = 3'd1;
	localparam logic [2:0] CFG_NORMAL_Z = 3'd2;
	localparam logic [2:0] CFG_RADIUS   = 3'd3;
	localparam logic [2:0] CFG_SWEEP    = 3'd4;

	// Register reset values.
	localparam logic [15:0] NORMAL_X_RST = 16'd0;
	localparam logic [15:0] NORMAL_Y_RST = 16'd0;
	localparam logic [15:0] NORMAL_Z_RST = 16'd4096;
	localparam logic [15:0] RADIUS_RST   = 16'd256;
	localparam logic [8:0]  SWEEP_RST    = 9'd90;

	localparam int unsigned MAX_SWEEP_DEFAULT = 360;

	// Angle constants in whole degrees.
	localparam int unsigned DEG_FULL     = 360;
	localparam int unsigned DEG_QUARTER  = 90;
	localparam int unsigned DEG_OCTANT   = 45;
	localparam int unsigned DEG_HALF     = 180;
	localparam int unsigned RED_PERIOD   = 30;
	// floor(x * RED_RECIP / 2^16) equals floor(x / 30) for x below 512.
	localparam int unsigned RED_RECIP    = 2185;

	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;
	localparam logic [63:0] HALF_Q30 = 64'd536870912;

	// Basis unit state machine.
	typedef enum logic [3:0] {
		B_SEED,
		B_DOT,
		B_VP,
		B_NLOAD,
		B_NMAX,
		B_NDOWN,
		B_NAPPLY,
		B_NUP,
		B_NSQ,
		B_NSQRT,
		B_NDIVI,
		B_NDIV,
		B_DONE
	} bstate_t;

	// Orthonormal basis handed from the basis unit to the pipeline (Q2.30).
	typedef struct packed {
		logic            done;
		logic [2:0][31:0] u;
		logic [2:0][31:0] v;
	} basis_t;

	typedef logic [DEG_OCTANT:0][30:0] trig_tab_t;
	typedef logic [DEG_HALF:0][7:0]    ramp_tab_t;
	typedef logic [RED_PERIOD-1:0][7:0] red_tab_t;

	// Product of two Q30 values, rounded half up.
	function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] p;
		p = a * b;
		return (p + HALF_Q30) >> 30;
	endfunction

	// Seven-term Taylor series for sine and cosine over 0 to 45 degrees.
	function automatic trig_tab_t build_trig(input bit want_cos);
		trig_tab_t   tab;
		logic [63:0] x, x2, ts, tc, s, c;
		tab = '0;
		for (int t = 0; t <= int'(DEG_OCTANT); t++) begin
			x  = (64'(t) * PI_Q30 + 64'd90) / 64'd180;
			x2 = mul_q30(x, x);
			ts = x;
			tc = ONE_Q30;
			s  = x;
			c  = ONE_Q30;
			ts = mul_q30(ts, x2) / 64'd6;    tc = mul_q30(tc, x2) / 64'd2;
			s  = s - ts;                     c  = c - tc;
			ts = mul_q30(ts, x2) / 64'd20;   tc = mul_q30(tc, x2) / 64'd12;
			s  = s + ts;                     c  = c + tc;
			ts = mul_q30(ts, x2) / 64'd42;   tc = mul_q30(tc, x2) / 64'd30;
			s  = s - ts;                     c  = c - tc;
			ts = mul_q30(ts, x2) / 64'd72;   tc = mul_q30(tc, x2) / 64'd56;
			s  = s + ts;                     c  = c + tc;
			ts = mul_q30(ts, x2) / 64'd110;  tc = mul_q30(tc, x2) / 64'd90;
			s  = s - ts;                     c  = c - tc;
			ts = mul_q30(ts, x2) / 64'd156;  tc = mul_q30(tc, x2) / 64'd132;
			s  = s + ts;                     c  = c + tc;
			tab[t] = want_cos ? c[30:0] : s[30:0];
		end
		return tab;
	endfunction

	// Green and blue ramp: round(g / 180 * 255) half up.
	function automatic ramp_tab_t build_ramp();
		ramp_tab_t tab;
		for (int g = 0; g <= int'(DEG_HALF); g++) begin
			tab[g] = 8'((64'(g) * 64'd510 + 64'd180) / 64'd360);
		end
		return tab;
	endfunction

	// Red ramp: round(((j + 20) / 100) * 255) half up.
	function automatic red_tab_t build_red();
		red_tab_t tab;
		for (int j = 0; j < int'(RED_PERIOD); j++) begin
			tab[j] = 8'(((64'(j) + 64'd20) * 64'd510 + 64'd100) / 64'd200);
		end
		return tab;
	endfunction

	localparam trig_tab_t SIN_TAB  = build_trig(1'b0);
	localparam trig_tab_t COS_TAB  = build_trig(1'b1);
	localparam ramp_tab_t RAMP_TAB = build_ramp();
	localparam red_tab_t  RED_TAB  = build_red();

endpackage

[src/pap_basis.sv]
// ----------------------------------------------------------------------------
// Arc basis unit
// Builds the two orthonormal vectors perpendicular to the normal with one
// shared multiplier, a bit-serial square root and a bit-serial divider.
// ----------------------------------------------------------------------------
module pap_basis (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] nx,
	input  logic signed [15:0] ny,
	input  logic signed [15:0] nz,
	output pap_pkg::basis_t    basis
);

	localparam int VW = 56;

	pap_pkg::bstate_t state_q, state_d;

	logic signed [17:0] w1_q [3];
	logic signed [17:0] w2_q [3];
	logic signed [17:0] w1_d [3];
	logic signed [17:0] w2_d [3];
	logic signed [35:0] d11_q, d21_q;
	logic signed [VW-1:0] vp_q [3];
	logic signed [VW-1:0] nv_q [3];
	logic [VW-1:0]      mx_q;
	logic [5:0]         sh_q;
	logic [1:0]         k_q;
	logic               sub_q;
	logic               target_q;
	logic [44:0]        n_q;
	logic [59:0]        rem_q, root_q, bit_q;
	logic [29:0]        drem_q;
	logic [31:0]        dlo_q, quo_q;
	logic [4:0]         cnt_q;
	logic signed [31:0] u_q [3];
	logic signed [31:0] v_q [3];
	logic               done_q;

	logic signed [35:0] mul_a;
	logic signed [23:0] mul_b;
	logic signed [59:0] prod;

	// Magnitude of the largest component.
	function automatic logic [VW-1:0] max_abs(input logic signed [VW-1:0] a,
			input logic signed [VW-1:0] b, input logic signed [VW-1:0] c);
		logic [VW-1:0] ma, mb, mc, m;
		ma = a[VW-1] ? VW'(-a) : VW'(a);
		mb = b[VW-1] ? VW'(-b) : VW'(b);
		mc = c[VW-1] ? VW'(-c) : VW'(c);
		m = ma;
		if (mb > m) m = mb;
		if (mc > m) m = mc;
		return m;
	endfunction

	// Right shift that rounds half away from zero.
	function automatic logic signed [VW-1:0] rshr(input logic signed [VW-1:0] v,
			input logic [5:0] s);
		logic [VW-1:0] m, rnd;
		m   = v[VW-1] ? VW'(-v) : VW'(v);
		rnd = (s == 6'd0) ? '0 : (VW'(1) << (s - 6'd1));
		m   = (m + rnd) >> s;
		return v[VW-1] ? VW'(-m) : VW'(m);
	endfunction

	// Seed vectors from the normal; all scaled to avoid division.
	always_comb begin
		logic signed [17:0] a, b, c, bc, abs_a, abs_b;
		a = 18'(nx);
		b = 18'(ny);
		c = 18'(nz);
		bc = b + c;
		abs_a = a[17] ? -a : a;
		abs_b = b[17] ? -b : b;
		if (a != 18'sd0) begin
			w1_d[0] = a[17] ? bc : -bc;
			w1_d[1] = abs_a;
			w1_d[2] = abs_a;
			w2_d[0] = a[17] ? b : -b;
			w2_d[1] = abs_a;
			w2_d[2] = 18'sd0;
		end else if (b != 18'sd0) begin
			w1_d[0] = abs_b;
			w1_d[1] = b[17] ? c : -c;
			w1_d[2] = abs_b;
			w2_d[0] = 18'sd1;
			w2_d[1] = 18'sd0;
			w2_d[2] = 18'sd0;
		end else begin
			w1_d[0] = 18'sd1;
			w1_d[1] = 18'sd1;
			w1_d[2] = 18'sd0;
			w2_d[0] = 18'sd0;
			w2_d[1] = 18'sd1;
			w2_d[2] = 18'sd0;
		end
	end

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			pap_pkg::B_DOT: begin
				mul_a = 36'(w1_q[k_q]);
				mul_b = sub_q ? 24'(w2_q[k_q]) : 24'(w1_q[k_q]);
			end
			pap_pkg::B_VP: begin
				mul_a = sub_q ? d21_q : d11_q;
				mul_b = sub_q ? 24'(w1_q[k_q]) : 24'(w2_q[k_q]);
			end
			pap_pkg::B_NSQ: begin
				mul_a = 36'(nv_q[k_q]);
				mul_b = 24'(nv_q[k_q]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Next state of the sequencer.
	always_comb begin
		logic [VW-1:0] m_now;
		m_now = max_abs(nv_q[0], nv_q[1], nv_q[2]);
		state_d = state_q;
		case (state_q)
			pap_pkg::B_SEED:   state_d = pap_pkg::B_DOT;
			pap_pkg::B_DOT:    if (sub_q && k_q == 2'd2) state_d = pap_pkg::B_VP;
			pap_pkg::B_VP:     if (sub_q && k_q == 2'd2) state_d = pap_pkg::B_NLOAD;
			pap_pkg::B_NLOAD:  state_d = pap_pkg::B_NMAX;
			pap_pkg::B_NMAX: begin
				if (m_now == '0) state_d = target_q ? pap_pkg::B_DONE : pap_pkg::B_NLOAD;
				else state_d = pap_pkg::B_NDOWN;
			end
			pap_pkg::B_NDOWN:  if (mx_q[VW-1:21] == '0) state_d = pap_pkg::B_NAPPLY;
			pap_pkg::B_NAPPLY: state_d = pap_pkg::B_NUP;
			pap_pkg::B_NUP:    if (m_now[VW-1:20] != '0) state_d = pap_pkg::B_NSQ;
			pap_pkg::B_NSQ:    if (k_q == 2'd2) state_d = pap_pkg::B_NSQRT;
			pap_pkg::B_NSQRT:  if (bit_q[0]) state_d = pap_pkg::B_NDIVI;
			pap_pkg::B_NDIVI:  state_d = pap_pkg::B_NDIV;
			pap_pkg::B_NDIV: begin
				if (cnt_q == 5'd31) begin
					if (k_q != 2'd2) state_d = pap_pkg::B_NDIVI;
					else state_d = target_q ? pap_pkg::B_DONE : pap_pkg::B_NLOAD;
				end
			end
			pap_pkg::B_DONE:   state_d = pap_pkg::B_DONE;
			default:           state_d = pap_pkg::B_SEED;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pap_pkg::B_SEED;
			done_q <= 1'b0;
		end else if (start) begin
			state_q <= pap_pkg::B_SEED;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_d == pap_pkg::B_DONE);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		logic [VW-1:0] m_now;
		logic [59:0]   sum;
		logic [59:0]   tabs, num;
		logic [30:0]   trial;
		logic          qbit;
		logic [31:0]   qn;
		logic [29:0]   s;
		m_now = max_abs(nv_q[0], nv_q[1], nv_q[2]);
		sum   = root_q + bit_q;
		s     = root_q[29:0];
		tabs  = nv_q[k_q][VW-1] ? 60'(-nv_q[k_q]) : 60'(nv_q[k_q]);
		num   = (tabs << 38) + 60'(s >> 1);
		trial = {drem_q, dlo_q[31]};
		qbit  = (trial >= {1'b0, s});
		qn    = {quo_q[30:0], qbit};
		case (state_q)
			pap_pkg::B_SEED: begin
				for (int k = 0; k < 3; k++) begin
					w1_q[k] <= w1_d[k];
					w2_q[k] <= w2_d[k];
				end
				d11_q <= '0;
				d21_q <= '0;
				k_q <= 2'd0;
				sub_q <= 1'b0;
				target_q <= 1'b0;
			end
			// Dot products s1.s1 and s2.s1.
			pap_pkg::B_DOT: begin
				if (sub_q) d21_q <= d21_q + 36'(prod);
				else d11_q <= d11_q + 36'(prod);
				sub_q <= ~sub_q;
				if (sub_q) k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
			end
			// Gram-Schmidt: vp = d11 * s2 - d21 * s1.
			pap_pkg::B_VP: begin
				if (sub_q) vp_q[k_q] <= vp_q[k_q] - VW'(prod);
				else vp_q[k_q] <= VW'(prod);
				sub_q <= ~sub_q;
				if (sub_q) k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
			end
			pap_pkg::B_NLOAD: begin
				for (int k = 0; k < 3; k++) begin
					nv_q[k] <= target_q ? vp_q[k] : VW'(w1_q[k]);
				end
			end
			pap_pkg::B_NMAX: begin
				mx_q <= m_now;
				sh_q <= 6'd0;
				if (m_now == '0) begin
					for (int k = 0; k < 3; k++) begin
						if (target_q) v_q[k] <= '0;
						else u_q[k] <= '0;
					end
					target_q <= 1'b1;
				end
			end
			// Count the right shift that brings the largest part below 2^21.
			pap_pkg::B_NDOWN: begin
				if (mx_q[VW-1:21] != '0) begin
					mx_q <= mx_q >> 1;
					sh_q <= sh_q + 6'd1;
				end
			end
			pap_pkg::B_NAPPLY: begin
				for (int k = 0; k < 3; k++) nv_q[k] <= rshr(nv_q[k], sh_q);
			end
			pap_pkg::B_NUP: begin
				if (m_now[VW-1:20] == '0) begin
					for (int k = 0; k < 3; k++) nv_q[k] <= nv_q[k] <<< 1;
				end else begin
					k_q <= 2'd0;
					n_q <= '0;
				end
			end
			// Squared length.
			pap_pkg::B_NSQ: begin
				n_q <= n_q + 45'(prod);
				k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				if (k_q == 2'd2) begin
					rem_q <= 60'({n_q + 45'(prod), 16'd0});
					root_q <= '0;
					bit_q <= 60'd1 << 58;
				end
			end
			// Square root, two radicand bits per cycle.
			pap_pkg::B_NSQRT: begin
				if (rem_q >= sum) begin
					rem_q <= rem_q - sum;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			pap_pkg::B_NDIVI: begin
				drem_q <= 30'(num[59:32]);
				dlo_q <= num[31:0];
				quo_q <= '0;
				cnt_q <= 5'd0;
			end
			// Restoring division, one quotient bit per cycle.
			pap_pkg::B_NDIV: begin
				drem_q <= qbit ? 30'(trial - {1'b0, s}) : trial[29:0];
				dlo_q <= dlo_q << 1;
				quo_q <= qn;
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					if (target_q) v_q[k_q] <= nv_q[k_q][VW-1] ? -$signed(qn) : $signed(qn);
					else u_q[k_q] <= nv_q[k_q][VW-1] ? -$signed(qn) : $signed(qn);
					if (k_q == 2'd2) begin
						k_q <= 2'd0;
						target_q <= 1'b1;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Basis toward the pipeline.
	always_comb begin
		basis.done = done_q;
		for (int k = 0; k < 3; k++) begin
			basis.u[k] = u_q[k];
			basis.v[k] = v_q[k];
		end
	end

endmodule

[src/perpendicular_arc_point_generator.sv]
// ----------------------------------------------------------------------------
// Perpendicular arc point generator
// Returns points of a circular arc in the plane perpendicular to a normal,
// with a color ramp, one degree index per transaction.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle through a six-stage pipeline with a stall chain.
// After reset and after any write to a normal register the basis unit rebuilds
// the plane vectors (sequential square root and divider); in_ready stays low
// meanwhile. Reset loads register defaults and empties the pipeline.
module perpendicular_arc_point_generator #(
	parameter int unsigned MAX_SWEEP_DEGREES = pap_pkg::MAX_SWEEP_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [8:0]         degree_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               point_valid,
	output logic signed [23:0] point_x,
	output logic signed [23:0] point_y,
	output logic signed [23:0] point_z,
	output logic [7:0]         color_red,
	output logic [7:0]         color_green,
	output logic [7:0]         color_blue
);

	localparam logic [8:0] SWEEP_MAX = 9'(MAX_SWEEP_DEGREES);

	logic signed [15:0] normal_x_q, normal_y_q, normal_z_q;
	logic [15:0]        radius_q;
	logic [8:0]         sweep_q;
	logic               cfg_wr, basis_start;
	pap_pkg::basis_t    basis;

	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic       ok_s1, swap_s1;
	logic [1:0] quad_s1;
	logic [5:0] ta_s1;
	logic [4:0] rem_s1;
	logic [7:0] g_s1;

	logic               ok_s2, ok_s3, ok_s4, ok_s5, ok_s6;
	logic signed [31:0] co_s2, si_s2;
	logic [7:0]         red_s2, green_s2, blue_s2;
	logic [7:0]         red_s3, green_s3, blue_s3;
	logic [7:0]         red_s4, green_s4, blue_s4;
	logic [7:0]         red_s5, green_s5, blue_s5;
	logic [7:0]         red_s6, green_s6, blue_s6;
	logic signed [63:0] cu_s3 [3];
	logic signed [63:0] sv_s3 [3];
	logic signed [32:0] p_s4 [3];
	logic signed [49:0] m_s5 [3];
	logic signed [23:0] pt_s6 [3];

	// Right shift by 30 that rounds half away from zero.
	function automatic logic signed [63:0] rshr30(input logic signed [63:0] v);
		logic [63:0] m;
		m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
		m = (m + 64'd536870912) >> 30;
		return v[63] ? $signed(64'd0 - m) : $signed(m);
	endfunction

	// Configuration registers; normal writes restart the basis unit.
	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign basis_start = cfg_wr && (cfg_index == pap_pkg::CFG_NORMAL_X ||
		cfg_index == pap_pkg::CFG_NORMAL_Y || cfg_index == pap_pkg::CFG_NORMAL_Z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_x_q <= pap_pkg::NORMAL_X_RST;
			normal_y_q <= pap_pkg::NORMAL_Y_RST;
			normal_z_q <= pap_pkg::NORMAL_Z_RST;
			radius_q <= pap_pkg::RADIUS_RST;
			sweep_q <= pap_pkg::SWEEP_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				pap_pkg::CFG_NORMAL_X: normal_x_q <= cfg_data;
				pap_pkg::CFG_NORMAL_Y: normal_y_q <= cfg_data;
				pap_pkg::CFG_NORMAL_Z: normal_z_q <= cfg_data;
				pap_pkg::CFG_RADIUS:   radius_q <= cfg_data;
				pap_pkg::CFG_SWEEP:    sweep_q <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	pap_basis u_basis (
		.clk   (clk),
		.arst_n(arst_n),
		.start (basis_start),
		.nx    (normal_x_q),
		.ny    (normal_y_q),
		.nz    (normal_z_q),
		.basis (basis)
	);

	// Stall chain: a stage loads when it is empty or the next one loads.
	assign en_s6 = !v_s6 || out_ready;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1 && basis.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid && in_ready;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: sweep check, angle reduction to an octant, ramp indexes.
	always_ff @(posedge clk) begin
		logic [8:0]  sweep_eff, r, t;
		logic [1:0]  quad;
		logic [20:0] qprod;
		logic [4:0]  q30;
		if (en_s1) begin
			sweep_eff = (sweep_q > SWEEP_MAX) ? SWEEP_MAX : sweep_q;
			r = (degree_index >= 9'(pap_pkg::DEG_FULL)) ?
				degree_index - 9'(pap_pkg::DEG_FULL) : degree_index;
			if (r < 9'(pap_pkg::DEG_QUARTER)) begin
				quad = 2'd0;
				t = r;
			end else if (r < 9'(2 * pap_pkg::DEG_QUARTER)) begin
				quad = 2'd1;
				t = r - 9'(pap_pkg::DEG_QUARTER);
			end else if (r < 9'(3 * pap_pkg::DEG_QUARTER)) begin
				quad = 2'd2;
				t = r - 9'(2 * pap_pkg::DEG_QUARTER);
			end else begin
				quad = 2'd3;
				t = r - 9'(3 * pap_pkg::DEG_QUARTER);
			end
			qprod = 21'(degree_index) * 21'(pap_pkg::RED_RECIP);
			q30 = qprod[20:16];
			ok_s1 <= (degree_index <= sweep_eff);
			quad_s1 <= quad;
			swap_s1 <= (t > 9'(pap_pkg::DEG_OCTANT));
			ta_s1 <= (t > 9'(pap_pkg::DEG_OCTANT)) ?
				6'(9'(pap_pkg::DEG_QUARTER) - t) : t[5:0];
			rem_s1 <= 5'(degree_index - 9'(q30) * 9'(pap_pkg::RED_PERIOD));
			g_s1 <= (degree_index > 9'(pap_pkg::DEG_HALF)) ?
				8'(pap_pkg::DEG_HALF) : degree_index[7:0];
		end
	end

	// Stage 2: table lookups and quadrant signs.
	always_ff @(posedge clk) begin
		logic signed [31:0] s, c;
		if (en_s2) begin
			s = $signed({1'b0, pap_pkg::SIN_TAB[ta_s1]});
			c = $signed({1'b0, pap_pkg::COS_TAB[ta_s1]});
			if (swap_s1) begin
				s = $signed({1'b0, pap_pkg::COS_TAB[ta_s1]});
				c = $signed({1'b0, pap_pkg::SIN_TAB[ta_s1]});
			end
			case (quad_s1)
				2'd0: begin co_s2 <= c;  si_s2 <= s;  end
				2'd1: begin co_s2 <= -s; si_s2 <= c;  end
				2'd2: begin co_s2 <= -c; si_s2 <= -s; end
				default: begin co_s2 <= s; si_s2 <= -c; end
			endcase
			ok_s2 <= ok_s1;
			red_s2 <= pap_pkg::RED_TAB[rem_s1];
			green_s2 <= pap_pkg::RAMP_TAB[g_s1];
			blue_s2 <= pap_pkg::RAMP_TAB[8'(pap_pkg::DEG_HALF) - g_s1];
		end
	end

	// Stage 3: cos * u and sin * v, two multipliers per lane.
	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int k = 0; k < 3; k++) begin
				cu_s3[k] <= co_s2 * $signed(basis.u[k]);
				sv_s3[k] <= si_s2 * $signed(basis.v[k]);
			end
			ok_s3 <= ok_s2;
			red_s3 <= red_s2;
			green_s3 <= green_s2;
			blue_s3 <= blue_s2;
		end
	end

	// Stage 4: direction vector component, back to 30 fraction bits.
	always_ff @(posedge clk) begin
		logic signed [63:0] r;
		if (en_s4) begin
			for (int k = 0; k < 3; k++) begin
				r = rshr30(cu_s3[k] + sv_s3[k]);
				p_s4[k] <= r[32:0];
			end
			ok_s4 <= ok_s3;
			red_s4 <= red_s3;
			green_s4 <= green_s3;
			blue_s4 <= blue_s3;
		end
	end

	// Stage 5: scale by the radius.
	always_ff @(posedge clk) begin
		if (en_s5) begin
			for (int k = 0; k < 3; k++) begin
				m_s5[k] <= p_s4[k] * $signed({1'b0, radius_q});
			end
			ok_s5 <= ok_s4;
			red_s5 <= red_s4;
			green_s5 <= green_s4;
			blue_s5 <= blue_s4;
		end
	end

	// Stage 6: final rounding into the output register; out-of-sweep reads zero.
	always_ff @(posedge clk) begin
		logic signed [63:0] r;
		if (en_s6) begin
			for (int k = 0; k < 3; k++) begin
				r = rshr30(64'(m_s5[k]));
				pt_s6[k] <= ok_s5 ? r[23:0] : 24'sd0;
			end
			ok_s6 <= ok_s5;
			red_s6 <= ok_s5 ? red_s5 : 8'd0;
			green_s6 <= ok_s5 ? green_s5 : 8'd0;
			blue_s6 <= ok_s5 ? blue_s5 : 8'd0;
		end
	end

	assign out_valid   = v_s6;
	assign point_valid = ok_s6;
	assign point_x     = pt_s6[0];
	assign point_y     = pt_s6[1];
	assign point_z     = pt_s6[2];
	assign color_red   = red_s6;
	assign color_green = green_s6;
	assign color_blue  = blue_s6;

endmodule

[src/pap_checker.sv]
// ----------------------------------------------------------------------------
// Arc point generator checker
// Port-level properties of the arc point generator, bound to the top level.
// ----------------------------------------------------------------------------
module pap_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic [2:0]         cfg_index,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               point_valid,
	input logic signed [23:0] point_x,
	input logic signed [23:0] point_y,
	input logic signed [23:0] point_z,
	input logic [7:0]         color_red,
	input logic [7:0]         color_green,
	input logic [7:0]         color_blue
);

	// A result outside the sweep carries all-zero fields.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> point_x == 24'sd0 && point_y == 24'sd0 &&
		point_z == 24'sd0 && color_red == 8'd0 && color_green == 8'd0 &&
		color_blue == 8'd0)
		else $error("out-of-sweep result has nonzero fields");

	// The red ramp stays between 0.2 and 0.49.
	a_red_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && point_valid |-> color_red >= 8'd51 && color_red <= 8'd125)
		else $error("red ramp out of range");

	// A normal write forces a basis rebuild, so input is held off next cycle.
	a_rebuild_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == pap_pkg::CFG_NORMAL_X ||
		cfg_index == pap_pkg::CFG_NORMAL_Y || cfg_index == pap_pkg::CFG_NORMAL_Z)
		|=> !in_ready)
		else $error("input accepted during basis rebuild");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(point_x) &&
		$stable(point_valid) && $stable(color_blue))
		else $error("stalled result changed");

endmodule

bind perpendicular_arc_point_generator pap_checker u_pap_checker (.*);

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Perpendicular arc point generator testbench
// Drives degree indices through the block under several normal, radius and
// sweep settings, predicts every arc point and color in fixed point, and
// compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------

// Expected content of one result transaction.
typedef struct packed {
	logic        pvalid;
	logic [23:0] px;
	logic [23:0] py;
	logic [23:0] pz;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
} arc_point_t;

// Arc point predictor with its own register copy and queue of pending points.
class arc_scoreboard;
	logic [15:0] nx, ny, nz, rad;
	logic [8:0]  sweep;
	int unsigned max_sweep;
	arc_point_t  pending_points[$];
	int unsigned mismatches;

	function new(int unsigned max_sw);
		max_sweep = max_sw;
		nx = pap_pkg::NORMAL_X_RST;
		ny = pap_pkg::NORMAL_Y_RST;
		nz = pap_pkg::NORMAL_Z_RST;
		rad = pap_pkg::RADIUS_RST;
		sweep = pap_pkg::SWEEP_RST;
		mismatches = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [15:0] data);
		case (idx)
			pap_pkg::CFG_NORMAL_X: nx = data;
			pap_pkg::CFG_NORMAL_Y: ny = data;
			pap_pkg::CFG_NORMAL_Z: nz = data;
			pap_pkg::CFG_RADIUS:   rad = data;
			pap_pkg::CFG_SWEEP:    sweep = data[8:0];
			default: ;
		endcase
	endfunction

	function int unsigned eff_sweep();
		return (sweep > max_sweep) ? max_sweep : sweep;
	endfunction

	// Shift right, rounding half away from zero.
	function longint shr_round(longint v, int s);
		longint unsigned m;
		if (s == 0)
			return v;
		m = (v < 0) ? -v : v;
		m = (m + (64'd1 << (s - 1))) >> s;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function longint div_round(longint num, longint den);
		longint unsigned m;
		m = (num < 0) ? -num : num;
		m = (m + longint'(den) / 2) / den;
		return (num < 0) ? -longint'(m) : longint'(m);
	endfunction

	function longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function longint abs_max(longint t[3]);
		longint m;
		m = (t[0] < 0) ? -t[0] : t[0];
		for (int k = 1; k < 3; k++)
			if (((t[k] < 0) ? -t[k] : t[k]) > m)
				m = (t[k] < 0) ? -t[k] : t[k];
		return m;
	endfunction

	// Unit vector with 30 fraction bits.
	function void unit_vec(input longint w[3], output longint uv[3]);
		longint t[3];
		longint m;
		longint unsigned n, s;
		int sh;
		m = abs_max(w);
		if (m == 0) begin
			uv = '{0, 0, 0};
			return;
		end
		sh = 0;
		while ((m >> sh) >= (64'sd1 << 21))
			sh++;
		for (int k = 0; k < 3; k++)
			t[k] = shr_round(w[k], sh);
		m = abs_max(t);
		while (m < (64'sd1 << 20)) begin
			for (int k = 0; k < 3; k++)
				t[k] = t[k] * 2;
			m = m * 2;
		end
		n = 0;
		for (int k = 0; k < 3; k++)
			n += longint'(t[k] * t[k]);
		s = int_sqrt(n << 16);
		for (int k = 0; k < 3; k++)
			uv[k] = div_round(t[k] * (64'sd1 << 38), longint'(s));
	endfunction

	// Cosine and sine of whole degrees with 30 fraction bits.
	function void trig_deg(input int unsigned d, output longint co, output longint si);
		int unsigned r, q, t;
		bit swap;
		longint unsigned x, x2, ts, tc;
		longint s, c, tmp;
		r = d % pap_pkg::DEG_FULL;
		q = r / pap_pkg::DEG_QUARTER;
		t = r % pap_pkg::DEG_QUARTER;
		swap = t > pap_pkg::DEG_OCTANT;
		if (swap)
			t = pap_pkg::DEG_QUARTER - t;
		x = (64'(t) * pap_pkg::PI_Q30 + 64'd90) / 64'd180;
		x2 = (x * x + (64'd1 << 29)) >> 30;
		ts = x;
		tc = pap_pkg::ONE_Q30;
		s = longint'(x);
		c = longint'(pap_pkg::ONE_Q30);
		for (int unsigned k = 1; k <= 6; k++) begin
			ts = ((ts * x2 + (64'd1 << 29)) >> 30) / ((2 * k) * (2 * k + 1));
			tc = ((tc * x2 + (64'd1 << 29)) >> 30) / ((2 * k - 1) * (2 * k));
			if (k & 1) begin
				s = s - longint'(ts);
				c = c - longint'(tc);
			end else begin
				s = s + longint'(ts);
				c = c + longint'(tc);
			end
		end
		if (swap) begin
			tmp = s;
			s = c;
			c = tmp;
		end
		case (q)
			0: begin co = c; si = s; end
			1: begin co = -s; si = c; end
			2: begin co = -c; si = -s; end
			default: begin co = s; si = -c; end
		endcase
	endfunction

	// Predict the result of one accepted degree index.
	function void note_degree(logic [8:0] deg);
		arc_point_t e;
		longint a, b, c, sg, d11, d21, co, si, p;
		longint w1[3], w2[3], vp[3], uu[3], vv[3];
		int unsigned i, g;
		i = deg;
		e = '{1'b0, '0, '0, '0, '0, '0, '0};
		if (i <= eff_sweep()) begin
			a = longint'($signed(nx));
			b = longint'($signed(ny));
			c = longint'($signed(nz));
			if (a == 0) begin
				if (b == 0) begin
					w1 = '{1, 1, 0};
					w2 = '{0, 1, 0};
				end else begin
					sg = (b < 0) ? -1 : 1;
					w1 = '{(b < 0) ? -b : b, -c * sg, (b < 0) ? -b : b};
					w2 = '{1, 0, 0};
				end
			end else begin
				sg = (a < 0) ? -1 : 1;
				w1 = '{-(b + c) * sg, (a < 0) ? -a : a, (a < 0) ? -a : a};
				w2 = '{-b * sg, (a < 0) ? -a : a, 0};
			end
			d11 = w1[0] * w1[0] + w1[1] * w1[1] + w1[2] * w1[2];
			d21 = w2[0] * w1[0] + w2[1] * w1[1] + w2[2] * w1[2];
			for (int k = 0; k < 3; k++)
				vp[k] = d11 * w2[k] - d21 * w1[k];
			unit_vec(w1, uu);
			unit_vec(vp, vv);
			trig_deg(i, co, si);
			e.pvalid = 1'b1;
			p = shr_round(shr_round(co * uu[0] + si * vv[0], 30) * longint'(rad), 30);
			e.px = p[23:0];
			p = shr_round(shr_round(co * uu[1] + si * vv[1], 30) * longint'(rad), 30);
			e.py = p[23:0];
			p = shr_round(shr_round(co * uu[2] + si * vv[2], 30) * longint'(rad), 30);
			e.pz = p[23:0];
			e.red = 8'((((i % pap_pkg::RED_PERIOD) + 20) * 510 + 100) / 200);
			g = (i > pap_pkg::DEG_HALF) ? pap_pkg::DEG_HALF : i;
			e.green = 8'((g * 510 + 180) / 360);
			e.blue = 8'(((pap_pkg::DEG_HALF - g) * 510 + 180) / 360);
		end
		pending_points = {pending_points, e};
	endfunction

	// Compare one result transaction with the oldest prediction.
	function void check_point(arc_point_t got);
		arc_point_t e;
		if (pending_points.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result transaction at %0t", $time);
			return;
		end
		e = pending_points.pop_front();
		if (got != e) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch at %0t: expected v=%0b x=%h y=%h z=%h rgb=%h %h %h",
					$time, e.pvalid, e.px, e.py, e.pz, e.red, e.green, e.blue);
				$display("    got v=%0b x=%h y=%h z=%h rgb=%h %h %h",
					got.pvalid, got.px, got.py, got.pz, got.red, got.green, got.blue);
			end
		end
	endfunction
endclass

module tb;

	localparam logic [2:0] CFG_SPARE_LO = pap_pkg::CFG_SWEEP + 3'd1;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned RANDOM_PHASES = 14;
	localparam int unsigned ITEMS_PER_PHASE = 80;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [8:0]         degree_index;
	logic               out_valid;
	logic               out_ready;
	logic               point_valid;
	logic signed [23:0] point_x;
	logic signed [23:0] point_y;
	logic signed [23:0] point_z;
	logic [7:0]         color_red;
	logic [7:0]         color_green;
	logic [7:0]         color_blue;

	arc_scoreboard arc_sb;
	bit            calm;
	int unsigned   idle_cycles;
	int unsigned   sink_count;
	bit            sink_stalling;

	perpendicular_arc_point_generator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.degree_index(degree_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.point_valid(point_valid),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.color_red(color_red),
		.color_green(color_green),
		.color_blue(color_blue)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Gap length: mostly none or short, a few long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Write one register and mirror it into the predictor.
	task automatic write_cfg(logic [2:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		arc_sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Send one degree index; valid stays high across back-to-back transactions.
	task automatic send_degree(logic [8:0] deg);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		degree_index <= deg;
		do
			@(posedge clk);
		while (!in_ready);
		arc_sb.note_degree(deg);
	endtask

	task automatic end_burst();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Let every pending result drain before touching the registers.
	task automatic wait_drained();
		while (arc_sb.pending_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_all(logic [15:0] x, logic [15:0] y, logic [15:0] z,
		logic [15:0] r, logic [15:0] s);
		write_cfg(pap_pkg::CFG_NORMAL_X, x);
		write_cfg(pap_pkg::CFG_NORMAL_Y, y);
		write_cfg(pap_pkg::CFG_NORMAL_Z, z);
		write_cfg(pap_pkg::CFG_RADIUS, r);
		write_cfg(pap_pkg::CFG_SWEEP, s);
	endtask

	// Random index: mostly within the sweep, sometimes anywhere.
	function automatic logic [8:0] pick_degree();
		int unsigned sw;
		sw = arc_sb.eff_sweep();
		if ($urandom_range(0, 3) == 0)
			return 9'($urandom_range(0, 511));
		if ($urandom_range(0, 7) == 0)
			return 9'($urandom_range(sw, (sw + 2 > 511) ? 511 : sw + 2));
		return 9'($urandom_range(0, sw));
	endfunction

	function automatic logic [15:0] pick_normal();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return '0;
		if (r < 4)
			return 16'($signed($urandom_range(0, 64)) - 32);
		return 16'($urandom);
	endfunction

	// Result sink with random stalls.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_count <= 0;
			sink_stalling <= 1'b1;
		end else if (sink_count != 0) begin
			sink_count <= sink_count - 1;
		end else if (sink_stalling) begin
			sink_stalling <= 1'b0;
			out_ready <= 1'b1;
			sink_count <= $urandom_range(0, 20);
		end else begin
			sink_stalling <= 1'b1;
			out_ready <= (pick_gap() == 0);
			sink_count <= pick_gap();
		end
	end

	// Check results and watch for lack of progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				arc_sb.check_point('{point_valid, point_x, point_y, point_z,
					color_red, color_green, color_blue});
			if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

	initial begin
		logic [8:0] corner_degrees[$];
		arc_sb = new(pap_pkg::MAX_SWEEP_DEFAULT);
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = pap_pkg::CFG_NORMAL_X;
		cfg_data = '0;
		in_valid = 1'b0;
		degree_index = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset defaults: octant, quadrant, ramp and sweep edges.
		corner_degrees = '{0, 1, 29, 30, 44, 45, 46, 89, 90, 91, 180, 181, 359, 360, 361, 511};
		foreach (corner_degrees[k])
			send_degree(corner_degrees[k]);
		end_burst();

		// Directed settings: zero normal, each seed case, register extremes.
		wait_drained();
		set_all(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'd360);
		foreach (corner_degrees[k])
			send_degree(corner_degrees[k]);
		end_burst();
		wait_drained();
		set_all(16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h01FF);
		send_degree(9'd0);
		send_degree(9'd270);
		send_degree(9'd360);
		send_degree(9'd361);
		end_burst();
		wait_drained();
		set_all(16'h8000, 16'h7FFF, 16'h8000, 16'h0001, 16'd361);
		send_degree(9'd135);
		send_degree(9'd315);
		send_degree(9'd511);
		end_burst();
		wait_drained();
		set_all(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'd0);
		send_degree(9'd0);
		send_degree(9'd1);
		end_burst();
		wait_drained();
		write_cfg(CFG_SPARE_LO, 16'hFFFF);
		write_cfg(CFG_SPARE_HI, 16'h1234);
		set_all(16'h0000, 16'h0005, 16'h0000, 16'h8000, 16'd359);
		send_degree(9'd0);
		send_degree(9'd359);
		send_degree(9'd360);
		end_burst();

		// Random settings, each followed by a burst of random indices.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_drained();
			calm = (ph % 4 == 3);
			if ($urandom_range(0, 3) == 0)
				write_cfg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 16'($urandom));
			set_all(pick_normal(), pick_normal(), pick_normal(), 16'($urandom),
				16'($urandom_range(0, 511)));
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_degree(pick_degree());
			end_burst();
		end

		wait_drained();
		if (arc_sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
src/pap_pkg.sv
src/pap_basis.sv
src/perpendicular_arc_point_generator.sv
src/pap_checker.sv
bench/tb.sv
